[sv/suffix_prefix_overlap_finder_core_defines.svh]
// assertion helpers shared by the checker
`ifndef SUFFIX_PREFIX_OVERLAP_FINDER_CORE_DEFINES_SVH
`define SUFFIX_PREFIX_OVERLAP_FINDER_CORE_DEFINES_SVH

// same-cycle implication
`define SPOF_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("spof check failed");

// next-cycle implication
`define SPOF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("spof check failed");

`endif

[sv/spof_pkg.sv]
package spof_pkg;

  localparam int MAX_LEN = 32;
  localparam int ADDR_W  = $clog2(MAX_LEN);
  localparam int LEN_W   = $clog2(MAX_LEN + 1);

  // fixed field widths
  localparam int OPC_W   = 2;
  localparam int CHAR_W  = 8;
  localparam int START_W = 5;
  localparam int SLEN_W  = 6;
  localparam int IN_W    = 16;
  localparam int OUT_W   = 16;

  typedef enum logic [1:0] {
    OP_APPEND_FIRST  = 2'd0,
    OP_APPEND_SECOND = 2'd1,
    OP_EVALUATE      = 2'd2,
    OP_CLEAR         = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CMP,
    ST_PUSH,
    ST_FIN
  } state_t;

endpackage

[sv/suffix_prefix_overlap_finder_core.sv]
// channel | dir | tdata (low bit up)                        | tuser      | tlast
// s       | in  | opcode[1:0], char_byte[9:2], zero pad      | -          | -
// m       | out | suffix_start[4:0], suffix_length[10:5], pad | none_found | last_result
//
// appends and clear are taken without leaving idle; the block is ready again on the next edge.
// evaluate walks candidate starts from the longest suffix that fits the second string;
// each character compare goes through the shared byte comparator
// (registered store read, then compare).
// rst is synchronous and clears both lengths; the stores need no clearing.
// a held result on m stalls the scan only when the next result needs the slot.
module suffix_prefix_overlap_finder_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [spof_pkg::IN_W-1:0]   s_tdata,   // opcode, char_byte
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [spof_pkg::OUT_W-1:0]  m_tdata,   // suffix_start, suffix_length
  output logic                        m_tuser,   // none_found
  output logic                        m_tlast    // last_result
);

  spof_pkg::state_t state, state_next;

  logic [spof_pkg::CHAR_W-1:0] first_mem  [spof_pkg::MAX_LEN];
  logic [spof_pkg::CHAR_W-1:0] second_mem [spof_pkg::MAX_LEN];

  logic [spof_pkg::LEN_W-1:0]  flen, slen;
  logic [spof_pkg::LEN_W-1:0]  start, k;
  logic [spof_pkg::ADDR_W-1:0] pend_start;
  logic                        have_pend;
  logic [spof_pkg::CHAR_W-1:0] fdat, sdat;

  logic [spof_pkg::OPC_W-1:0]  opcode;
  logic [spof_pkg::CHAR_W-1:0] char_byte;
  logic                        accept, out_free, load_out, out_last, out_none;
  logic                        start_last, suffix_done, byte_eq;
  logic [spof_pkg::LEN_W-1:0]  rd_addr, start_first, pend_len;

  assign opcode    = s_tdata[spof_pkg::OPC_W-1:0];
  assign char_byte = s_tdata[spof_pkg::OPC_W +: spof_pkg::CHAR_W];
  assign accept    = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;

  // shared compare unit
  assign byte_eq     = (fdat == sdat);
  assign rd_addr     = start + k;
  assign start_last  = (start + spof_pkg::LEN_W'(1) == flen);
  assign suffix_done = (k + spof_pkg::LEN_W'(1) == flen - start);
  // longest suffix that can fit in the second string
  assign start_first = (flen > slen) ? flen - slen : '0;
  assign pend_len    = flen - spof_pkg::LEN_W'(pend_start);

  always_comb begin
    state_next = state;
    case (state)
      spof_pkg::ST_IDLE: begin
        if (accept && opcode == spof_pkg::OP_EVALUATE) begin
          // nothing can match when either string is empty
          state_next = (flen == '0 || slen == '0) ? spof_pkg::ST_FIN : spof_pkg::ST_READ;
        end
      end
      spof_pkg::ST_READ: state_next = spof_pkg::ST_CMP;
      spof_pkg::ST_CMP: begin
        if (!byte_eq) begin
          state_next = start_last ? spof_pkg::ST_FIN : spof_pkg::ST_READ;
        end else if (suffix_done) begin
          state_next = spof_pkg::ST_PUSH;
        end else begin
          state_next = spof_pkg::ST_READ;
        end
      end
      spof_pkg::ST_PUSH: begin
        if (!have_pend || out_free) begin
          state_next = start_last ? spof_pkg::ST_FIN : spof_pkg::ST_READ;
        end
      end
      spof_pkg::ST_FIN: begin
        if (out_free) begin
          state_next = spof_pkg::ST_IDLE;
        end
      end
      default: state_next = spof_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready = 1'b0;
    load_out = 1'b0;
    out_last = 1'b0;
    out_none = 1'b0;
    case (state)
      spof_pkg::ST_IDLE: s_tready = 1'b1;
      spof_pkg::ST_PUSH: load_out = have_pend && out_free;
      spof_pkg::ST_FIN: begin
        load_out = out_free;
        out_last = 1'b1;
        out_none = !have_pend;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= spof_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // character stores: one write and one registered read each
  always_ff @(posedge clk) begin
    if (accept && opcode == spof_pkg::OP_APPEND_FIRST &&
        flen < spof_pkg::LEN_W'(spof_pkg::MAX_LEN)) begin
      first_mem[flen[spof_pkg::ADDR_W-1:0]] <= char_byte;
    end
    if (accept && opcode == spof_pkg::OP_APPEND_SECOND &&
        slen < spof_pkg::LEN_W'(spof_pkg::MAX_LEN)) begin
      second_mem[slen[spof_pkg::ADDR_W-1:0]] <= char_byte;
    end
    if (state == spof_pkg::ST_READ) begin
      fdat <= first_mem[rd_addr[spof_pkg::ADDR_W-1:0]];
      sdat <= second_mem[k[spof_pkg::ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flen <= '0;
      slen <= '0;
    end else if (accept) begin
      case (opcode)
        spof_pkg::OP_APPEND_FIRST: begin
          if (flen < spof_pkg::LEN_W'(spof_pkg::MAX_LEN)) flen <= flen + spof_pkg::LEN_W'(1);
        end
        spof_pkg::OP_APPEND_SECOND: begin
          if (slen < spof_pkg::LEN_W'(spof_pkg::MAX_LEN)) slen <= slen + spof_pkg::LEN_W'(1);
        end
        spof_pkg::OP_CLEAR: begin
          flen <= '0;
          slen <= '0;
        end
        default: begin
          flen <= flen;
        end
      endcase
    end
  end

  // scan counters and the held match
  always_ff @(posedge clk) begin
    if (rst) begin
      have_pend <= 1'b0;
    end else begin
      case (state)
        spof_pkg::ST_IDLE: begin
          if (accept && opcode == spof_pkg::OP_EVALUATE) begin
            start     <= start_first;
            k         <= '0;
            have_pend <= 1'b0;
          end
        end
        spof_pkg::ST_CMP: begin
          if (!byte_eq) begin
            start <= start + spof_pkg::LEN_W'(1);
            k     <= '0;
          end else if (!suffix_done) begin
            k <= k + spof_pkg::LEN_W'(1);
          end
        end
        spof_pkg::ST_PUSH: begin
          if (!have_pend || out_free) begin
            pend_start <= start[spof_pkg::ADDR_W-1:0];
            have_pend  <= 1'b1;
            start      <= start + spof_pkg::LEN_W'(1);
            k          <= '0;
          end
        end
        default: begin
          k <= k;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      if (out_none) begin
        m_tdata <= '0;
      end else begin
        m_tdata <= {{(spof_pkg::OUT_W - spof_pkg::START_W - spof_pkg::SLEN_W){1'b0}},
                    spof_pkg::SLEN_W'(pend_len), spof_pkg::START_W'(pend_start)};
      end
      m_tuser <= out_none;
      m_tlast <= out_last;
    end
  end

endmodule

[sv/spof_checker.sv]
`include "suffix_prefix_overlap_finder_core_defines.svh"

module spof_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        s_tvalid,
  input logic                        s_tready,
  input logic [spof_pkg::IN_W-1:0]   s_tdata,
  input logic                        m_tvalid,
  input logic                        m_tready,
  input logic [spof_pkg::OUT_W-1:0]  m_tdata,
  input logic                        m_tuser,
  input logic                        m_tlast
);

  logic eval_acc, other_acc;

  assign eval_acc  = s_tvalid && s_tready &&
                     s_tdata[spof_pkg::OPC_W-1:0] == spof_pkg::OP_EVALUATE;
  assign other_acc = s_tvalid && s_tready &&
                     s_tdata[spof_pkg::OPC_W-1:0] != spof_pkg::OP_EVALUATE;

  // a no-match result closes its run and carries no length
  `SPOF_ASSERT_NOW(a_none_is_last, m_tvalid && m_tuser, m_tlast && m_tdata[10:5] == 6'd0)
  // a real match is never empty
  `SPOF_ASSERT_NOW(a_match_len, m_tvalid && !m_tuser, m_tdata[10:5] != 6'd0)
  // after a load or clear the block is ready again in the next cycle
  `SPOF_ASSERT_NEXT(a_load_one_cycle, other_acc, s_tready)
  // evaluate always occupies the scan for a while
  `SPOF_ASSERT_NEXT(a_eval_busy, eval_acc, !s_tready)
  // stalled result holds
  `SPOF_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready,
                    m_tvalid && $stable(m_tdata) && $stable(m_tlast))

endmodule

bind suffix_prefix_overlap_finder_core spof_checker u_spof_checker (.*);

[verif/tb_suffix_prefix_overlap_finder_core.sv]
module tb_suffix_prefix_overlap_finder_core;

  typedef struct packed {
    logic [spof_pkg::START_W-1:0] start;
    logic [spof_pkg::SLEN_W-1:0]  length;
    logic                         none_found;
    logic                         last_result;
  } overlap_t;

  logic                          clk;
  logic                          rst;
  logic                          s_tvalid;
  logic                          s_tready;
  logic [spof_pkg::IN_W-1:0]     s_tdata;   // opcode, char_byte
  logic                          m_tvalid;
  logic                          m_tready;
  logic [spof_pkg::OUT_W-1:0]    m_tdata;   // suffix_start, suffix_length
  logic                          m_tuser;   // none_found
  logic                          m_tlast;   // last_result

  // predictor copy of the two strings
  logic [spof_pkg::CHAR_W-1:0]   first_chars [spof_pkg::MAX_LEN];
  logic [spof_pkg::CHAR_W-1:0]   second_chars [spof_pkg::MAX_LEN];
  int unsigned         first_len;
  int unsigned         second_len;

  overlap_t            overlap_q[$];
  int unsigned         gap_max;
  int unsigned         stall_max;
  int unsigned         hold_cycles;
  int unsigned         items_sent;
  int unsigned         evaluates_sent;
  int unsigned         results_seen;
  int unsigned         longest_run;
  int unsigned         mismatch_count;

  suffix_prefix_overlap_finder_core i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #2 clk = ~clk;

  // applies one accepted item to the predictor and queues the overlaps it yields
  function automatic void predict_overlaps(spof_pkg::opcode_t op,
                                           logic [spof_pkg::CHAR_W-1:0] ch);
    int unsigned run_len;
    int unsigned sfx_len;
    bit          hit;
    overlap_t    ov;
    run_len = 0;
    case (op)
      spof_pkg::OP_APPEND_FIRST: begin
        if (first_len < spof_pkg::MAX_LEN) begin
          first_chars[first_len] = ch;
          first_len++;
        end
      end
      spof_pkg::OP_APPEND_SECOND: begin
        if (second_len < spof_pkg::MAX_LEN) begin
          second_chars[second_len] = ch;
          second_len++;
        end
      end
      spof_pkg::OP_CLEAR: begin
        first_len  = 0;
        second_len = 0;
      end
      default: begin
        for (int i = 0; i < first_len; i++) begin
          sfx_len = first_len - i;
          hit = (sfx_len <= second_len);
          for (int k = 0; hit && k < sfx_len; k++)
            if (first_chars[i + k] != second_chars[k]) hit = 0;
          if (hit) begin
            ov.start       = i[spof_pkg::START_W-1:0];
            ov.length      = sfx_len[spof_pkg::SLEN_W-1:0];
            ov.none_found  = 1'b0;
            ov.last_result = 1'b0;
            overlap_q.push_back(ov);
            run_len++;
          end
        end
        if (run_len == 0) begin
          ov = '{start: '0, length: '0, none_found: 1'b1, last_result: 1'b1};
          overlap_q.push_back(ov);
          run_len = 1;
        end else begin
          overlap_q[overlap_q.size() - 1].last_result = 1'b1;
        end
        if (run_len > longest_run) longest_run = run_len;
        evaluates_sent++;
      end
    endcase
  endfunction

  task automatic send_item(spof_pkg::opcode_t op, logic [spof_pkg::CHAR_W-1:0] ch);
    int unsigned gap;
    gap = $urandom_range(0, gap_max);
    @(negedge clk);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(spof_pkg::IN_W - spof_pkg::OPC_W - spof_pkg::CHAR_W){1'b0}}, ch, op};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_overlaps(op, ch);
    items_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (overlap_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic report_mismatch(string what, overlap_t want, overlap_t got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display({"mismatch (%s): expected start %0d len %0d none %0b last %0b,",
                " got start %0d len %0d none %0b last %0b"},
               what, want.start, want.length, want.none_found, want.last_result,
               got.start, got.length, got.none_found, got.last_result);
  endtask

  always @(posedge clk) begin
    overlap_t got;
    overlap_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.start       = m_tdata[spof_pkg::START_W-1:0];
      got.length      = m_tdata[spof_pkg::START_W +: spof_pkg::SLEN_W];
      got.none_found  = m_tuser;
      got.last_result = m_tlast;
      results_seen++;
      if (overlap_q.size() == 0) begin
        report_mismatch("unexpected item", '0, got);
      end else begin
        want = overlap_q.pop_front();
        if (got !== want) report_mismatch("field", want, got);
      end
    end
  end

  // result side: random stalls per item, plus a long hold-off on request
  initial begin
    int unsigned stall;
    m_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = $urandom_range(0, stall_max);
      if (hold_cycles != 0) begin
        stall = hold_cycles;
        hold_cycles = 0;
      end
      if (stall != 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid && hold_cycles == 0) @(posedge clk);
      @(negedge clk);
    end
  end

  task automatic send_string(spof_pkg::opcode_t op, logic [spof_pkg::CHAR_W-1:0] chars[$]);
    foreach (chars[i]) send_item(op, chars[i]);
  endtask

  task automatic test_empty_strings();
    send_item(spof_pkg::OP_EVALUATE, 8'hA5);
    send_item(spof_pkg::OP_APPEND_SECOND, 8'h41);
    send_item(spof_pkg::OP_EVALUATE, 8'h5A);
  endtask

  task automatic test_extreme_chars();
    // zero byte is an ordinary character
    send_item(spof_pkg::OP_CLEAR, 8'hFF);
    send_string(spof_pkg::OP_APPEND_FIRST, '{8'h00, 8'hFF, 8'h00});
    send_string(spof_pkg::OP_APPEND_SECOND, '{8'h00, 8'hFF, 8'h00, 8'h55});
    send_item(spof_pkg::OP_EVALUATE, 8'h00);
    send_item(spof_pkg::OP_EVALUATE, 8'hFF);
  endtask

  task automatic test_short_second();
    // suffixes longer than the second string cannot match
    send_item(spof_pkg::OP_CLEAR, 8'h00);
    send_string(spof_pkg::OP_APPEND_FIRST, '{8'hAA, 8'hAA, 8'hAA, 8'hAA});
    send_string(spof_pkg::OP_APPEND_SECOND, '{8'hAA, 8'hAA});
    send_item(spof_pkg::OP_EVALUATE, 8'h00);
    send_item(spof_pkg::OP_APPEND_SECOND, 8'h55);
    send_item(spof_pkg::OP_EVALUATE, 8'h00);
  endtask

  task automatic test_full_store_backpressure();
    gap_max   = 0;
    stall_max = 0;
    wait_drained();
    hold_cycles = 400;
    send_item(spof_pkg::OP_CLEAR, 8'h00);
    for (int i = 0; i < spof_pkg::MAX_LEN + 2; i++) begin
      send_item(spof_pkg::OP_APPEND_FIRST, 8'h7E);
      send_item(spof_pkg::OP_APPEND_SECOND, 8'h7E);
    end
    send_item(spof_pkg::OP_EVALUATE, 8'h00);
    send_item(spof_pkg::OP_EVALUATE, 8'h00);
    send_item(spof_pkg::OP_APPEND_FIRST, 8'h01);
    send_item(spof_pkg::OP_EVALUATE, 8'h00);
    wait_drained();
  endtask

  task automatic test_random_sequences(int unsigned item_target);
    int unsigned      start_count;
    int unsigned      flen;
    int unsigned      olap;
    int unsigned      tail;
    int unsigned      nsym;
    int unsigned      fi;
    int unsigned      si;
    logic [spof_pkg::CHAR_W-1:0] sym [4];
    logic [spof_pkg::CHAR_W-1:0] fstr[$];
    logic [spof_pkg::CHAR_W-1:0] sstr[$];
    start_count = items_sent;
    while (items_sent - start_count < item_target) begin
      gap_max   = ($urandom_range(0, 2) == 0) ? 0 : 16;
      stall_max = ($urandom_range(0, 2) == 0) ? 0 : 16;
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 8))
          send_item(spof_pkg::opcode_t'($urandom_range(0, 3)),
                    spof_pkg::CHAR_W'($urandom_range(0, 255)));
      end else begin
        nsym = $urandom_range(1, 4);
        foreach (sym[j]) sym[j] = spof_pkg::CHAR_W'($urandom_range(0, 255));
        flen = ($urandom_range(0, 9) == 0) ? $urandom_range(20, spof_pkg::MAX_LEN + 2)
                                           : $urandom_range(0, 8);
        fstr.delete();
        sstr.delete();
        repeat (flen) fstr.push_back(sym[$urandom_range(0, nsym - 1)]);
        // second string starts with a chosen suffix of the first, then random tail
        olap = (flen == 0) ? 0 : $urandom_range(0, flen);
        tail = $urandom_range(0, 6);
        for (int k = flen - olap; k < flen; k++) sstr.push_back(fstr[k]);
        repeat (tail) sstr.push_back(sym[$urandom_range(0, nsym - 1)]);
        if ($urandom_range(0, 5) == 0 && sstr.size() > 0)
          sstr[$urandom_range(0, sstr.size() - 1)] ^= 8'(1 << $urandom_range(0, 7));
        send_item(spof_pkg::OP_CLEAR, spof_pkg::CHAR_W'($urandom_range(0, 255)));
        fi = 0;
        si = 0;
        while (fi < fstr.size() || si < sstr.size()) begin
          if (si >= sstr.size() || (fi < fstr.size() && $urandom_range(0, 1) == 0)) begin
            send_item(spof_pkg::OP_APPEND_FIRST, fstr[fi]);
            fi++;
          end else begin
            send_item(spof_pkg::OP_APPEND_SECOND, sstr[si]);
            si++;
          end
        end
        send_item(spof_pkg::OP_EVALUATE, spof_pkg::CHAR_W'($urandom_range(0, 255)));
        if ($urandom_range(0, 3) == 0) begin
          send_item(spof_pkg::opcode_t'($urandom_range(0, 1)),
                    sym[$urandom_range(0, nsym - 1)]);
          send_item(spof_pkg::OP_EVALUATE, spof_pkg::CHAR_W'($urandom_range(0, 255)));
        end
      end
    end
  endtask

  initial begin
    clk            = 1'b0;
    rst            = 1'b1;
    s_tvalid       = 1'b0;
    s_tdata        = '0;
    gap_max        = 16;
    stall_max      = 16;
    hold_cycles    = 0;
    items_sent     = 0;
    evaluates_sent = 0;
    results_seen   = 0;
    longest_run    = 0;
    mismatch_count = 0;
    first_len      = 0;
    second_len     = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_empty_strings();
    test_extreme_chars();
    test_short_second();
    test_full_store_backpressure();
    test_random_sequences(210);

    @(negedge clk);
    s_tvalid <= 1'b0;
    wait_drained();
    repeat (40) @(posedge clk);
    if (overlap_q.size() != 0) mismatch_count++;

    $display("run covered %0d items with %0d evaluates, %0d results checked",
             items_sent, evaluates_sent, results_seen);
    $display("longest evaluate run %0d results, mismatches %0d", longest_run, mismatch_count);
    if (mismatch_count == 0) begin
      $display("suffix_prefix_overlap_finder_core test passed");
    end else begin
      $display("suffix_prefix_overlap_finder_core test failed");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("suffix_prefix_overlap_finder_core test failed");
    $finish;
  end

endmodule

[sim.f]
+incdir+sv
sv/spof_pkg.sv
sv/suffix_prefix_overlap_finder_core.sv
sv/spof_checker.sv
verif/tb_suffix_prefix_overlap_finder_core.sv
